@@ design/assert_macros.svh @@
// Assertion macros for the design files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define NSHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define NSHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/nsht_pkg.sv @@
// Shared types and constants of the nearest segment hit test.
package nsht_pkg;

    localparam int DIST_BITS    = 26;
    localparam int OUT_IDX_BITS = 6;

    typedef logic [DIST_BITS-1:0] dist_t;

    localparam dist_t DIST_MAX     = '1;
    localparam dist_t THRESH_RESET = 26'd100;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

endpackage

@@ design/nsht_seg_dist.sv @@
// Iterative squared point-to-segment distance unit; shared multiplier and divide subtractor.
module nsht_seg_dist
    import nsht_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] xa,
    input  logic signed [COORD_BITS-1:0] ya,
    input  logic signed [COORD_BITS-1:0] xb,
    input  logic signed [COORD_BITS-1:0] yb,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    output logic                         done,
    output dist_t                        sq_dist
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam int EW = 2 * COORD_BITS + 1;
    localparam int RW = EW + 1;
    localparam int BW = $clog2(EW);
    localparam int SW = (EW > DIST_BITS) ? EW : DIST_BITS;
    localparam logic [3:0] MUL_STEPS = 4'd8;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DIFF    = 8'b0000_0010,
        S_MUL     = 8'b0000_0100,
        S_CHK     = 8'b0000_1000,
        S_DIV_SH  = 8'b0001_0000,
        S_DIV_ADD = 8'b0010_0000,
        S_SUB     = 8'b0100_0000,
        S_FIN     = 8'b1000_0000
    } dstate_t;

    dstate_t state_reg, state_next;
    logic [3:0]    step_reg, step_next;
    logic [BW-1:0] bit_reg, bit_next;

    logic signed [COORD_BITS-1:0] xa_reg, xa_next, ya_reg, ya_next;
    logic signed [COORD_BITS-1:0] xb_reg, xb_next, yb_reg, yb_next;
    logic signed [COORD_BITS-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [DW-1:0] abx_reg, abx_next, aby_reg, aby_next;
    logic signed [DW-1:0] acx_reg, acx_next, acy_reg, acy_next;
    logic signed [DW-1:0] bcx_reg, bcx_next, bcy_reg, bcy_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [PW-1:0] e_reg, e_next, f_reg, f_next;
    logic signed [PW-1:0] da_reg, da_next, db_reg, db_next;
    logic [RW-1:0] r_reg, r_next;
    logic [EW-1:0] q_reg, q_next;
    logic [EW-1:0] d_reg, d_next;

    logic signed [DW-1:0] op_a, op_b;
    logic signed [PW-1:0] prod_full, acc_cur, acc_in;
    logic [2:0]    acc_sel;
    logic [EW-1:0] e_u, f_u, da_u, db_u;
    logic [RW-1:0] r_try, r_new;
    logic          r_ge;
    logic [EW-1:0] q_base, q_new;
    logic [SW-1:0] d_ext;

    assign e_u  = e_reg[EW-1:0];
    assign f_u  = f_reg[EW-1:0];
    assign da_u = da_reg[EW-1:0];
    assign db_u = db_reg[EW-1:0];

    // shared multiplier operand select
    always_comb
    begin
        unique case (step_reg[2:0])
            3'd0:
            begin
                op_a = acx_reg;
                op_b = abx_reg;
            end
            3'd1:
            begin
                op_a = acy_reg;
                op_b = aby_reg;
            end
            3'd2:
            begin
                op_a = abx_reg;
                op_b = abx_reg;
            end
            3'd3:
            begin
                op_a = aby_reg;
                op_b = aby_reg;
            end
            3'd4:
            begin
                op_a = acx_reg;
                op_b = acx_reg;
            end
            3'd5:
            begin
                op_a = acy_reg;
                op_b = acy_reg;
            end
            3'd6:
            begin
                op_a = bcx_reg;
                op_b = bcx_reg;
            end
            3'd7:
            begin
                op_a = bcy_reg;
                op_b = bcy_reg;
            end
        endcase
    end

    assign prod_full = op_a * op_b;
    assign acc_sel   = 3'(step_reg - 4'd1);

    always_comb
    begin
        unique case (acc_sel[2:1])
            2'd0: acc_cur = e_reg;
            2'd1: acc_cur = f_reg;
            2'd2: acc_cur = da_reg;
            2'd3: acc_cur = db_reg;
        endcase
    end

    assign acc_in = acc_sel[0] ? (acc_cur + prod_reg) : prod_reg;

    // shared compare-subtract for the restoring division of e*e by f
    assign r_try  = (state_reg == S_DIV_SH) ? {r_reg[EW-1:0], 1'b0} : (r_reg + RW'(e_u));
    assign r_ge   = (r_try >= RW'(f_u));
    assign r_new  = r_ge ? (r_try - RW'(f_u)) : r_try;
    assign q_base = (state_reg == S_DIV_SH) ? {q_reg[EW-2:0], 1'b0} : q_reg;
    assign q_new  = q_base + EW'(r_ge);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        xa_next    = xa_reg;
        ya_next    = ya_reg;
        xb_next    = xb_reg;
        yb_next    = yb_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        abx_next   = abx_reg;
        aby_next   = aby_reg;
        acx_next   = acx_reg;
        acy_next   = acy_reg;
        bcx_next   = bcx_reg;
        bcy_next   = bcy_reg;
        prod_next  = prod_reg;
        e_next     = e_reg;
        f_next     = f_reg;
        da_next    = da_reg;
        db_next    = db_reg;
        r_next     = r_reg;
        q_next     = q_reg;
        d_next     = d_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    xa_next    = xa;
                    ya_next    = ya;
                    xb_next    = xb;
                    yb_next    = yb;
                    px_next    = px;
                    py_next    = py;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                abx_next   = DW'(xb_reg) - DW'(xa_reg);
                aby_next   = DW'(yb_reg) - DW'(ya_reg);
                acx_next   = DW'(px_reg) - DW'(xa_reg);
                acy_next   = DW'(py_reg) - DW'(ya_reg);
                bcx_next   = DW'(px_reg) - DW'(xb_reg);
                bcy_next   = DW'(py_reg) - DW'(yb_reg);
                step_next  = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (step_reg != MUL_STEPS)
                begin
                    prod_next = prod_full;
                end
                if (step_reg != 4'd0)
                begin
                    unique case (acc_sel[2:1])
                        2'd0: e_next  = acc_in;
                        2'd1: f_next  = acc_in;
                        2'd2: da_next = acc_in;
                        2'd3: db_next = acc_in;
                    endcase
                end
                if (step_reg == MUL_STEPS)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_CHK:
            begin
                priority if (e_reg[PW-1] || (e_reg == '0))
                begin
                    d_next     = da_u;
                    state_next = S_FIN;
                end
                else if (e_reg >= f_reg)
                begin
                    d_next     = db_u;
                    state_next = S_FIN;
                end
                else
                begin
                    r_next     = '0;
                    q_next     = '0;
                    bit_next   = BW'(EW - 1);
                    state_next = S_DIV_SH;
                end
            end
            S_DIV_SH:
            begin
                r_next = r_new;
                q_next = q_new;
                priority if (e_u[bit_reg])
                begin
                    state_next = S_DIV_ADD;
                end
                else if (bit_reg == '0)
                begin
                    state_next = S_SUB;
                end
                else
                begin
                    bit_next = bit_reg - BW'(1);
                end
            end
            S_DIV_ADD:
            begin
                r_next = r_new;
                q_next = q_new;
                if (bit_reg == '0)
                begin
                    state_next = S_SUB;
                end
                else
                begin
                    bit_next   = bit_reg - BW'(1);
                    state_next = S_DIV_SH;
                end
            end
            S_SUB:
            begin
                d_next     = da_u - q_reg;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xa_reg   <= xa_next;
        ya_reg   <= ya_next;
        xb_reg   <= xb_next;
        yb_reg   <= yb_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        abx_reg  <= abx_next;
        aby_reg  <= aby_next;
        acx_reg  <= acx_next;
        acy_reg  <= acy_next;
        bcx_reg  <= bcx_next;
        bcy_reg  <= bcy_next;
        prod_reg <= prod_next;
        e_reg    <= e_next;
        f_reg    <= f_next;
        da_reg   <= da_next;
        db_reg   <= db_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
    end

    // saturate to the result width
    assign d_ext   = SW'(d_reg);
    assign sq_dist = (d_ext > SW'(DIST_MAX)) ? DIST_MAX : d_ext[DIST_BITS-1:0];
    assign done    = (state_reg == S_FIN);

endmodule

@@ design/nearest_segment_hit_test.sv @@
// Top level of the nearest segment hit test: segment table, search sequencer, result register.
//
// Channel   Dir  Transfer at edge        Fields
// command   in   start && !busy          action, x_a, y_a, x_b, y_b
// result    out  result_valid (1 cycle)  hit, seg_index, best_dist, full_error
// config    in   cfg_we                  cfg_wdata (hit threshold)
//
// For append, clear and unknown actions the result shows the next cycle.
// A query on an empty table answers the next cycle; otherwise each stored segment
// passes through the fetch, launch and wait states, waiting on the shared distance unit
// and its bit-serial division; busy is high meanwhile.
// Reset empties the table and loads a threshold of 100; no clearing pass is needed.
// The result strobe lasts one cycle and cannot be held off.
`include "assert_macros.svh"

module nearest_segment_hit_test
    import nsht_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   action,
    input  logic signed [COORD_BITS-1:0] x_a,
    input  logic signed [COORD_BITS-1:0] y_a,
    input  logic signed [COORD_BITS-1:0] x_b,
    input  logic signed [COORD_BITS-1:0] y_b,
    input  logic                         cfg_we,
    input  logic [DIST_BITS-1:0]         cfg_wdata,
    output logic                         result_valid,
    output logic                         hit,
    output logic [OUT_IDX_BITS-1:0]      seg_index,
    output logic [DIST_BITS-1:0]         best_dist,
    output logic                         full_error
);

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int ENT_W = 4 * COORD_BITS;
    localparam int OX_W  = IDX_W + OUT_IDX_BITS;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FETCH  = 4'b0010,
        ST_LAUNCH = 4'b0100,
        ST_WAIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cur_idx_reg, cur_idx_next;
    dist_t            thr_reg, thr_next;
    logic             res_valid_reg, res_valid_next;

    logic             hit_reg, hit_next;
    logic [OUT_IDX_BITS-1:0] seg_index_reg, seg_index_next;
    dist_t            best_dist_reg, best_dist_next;
    logic             full_error_reg, full_error_next;
    dist_t            best_run_reg, best_run_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic signed [COORD_BITS-1:0] px_reg, px_next, py_reg, py_next;

    logic [ENT_W-1:0] seg_mem [MAX_SEGMENTS];
    logic [ENT_W-1:0] rd_data_reg;
    logic             mem_we;

    logic             accept;
    logic             full;
    logic             last;
    logic             unit_start;
    logic             unit_done;
    dist_t            unit_dist;
    logic             take;
    dist_t            cand_best;
    logic [IDX_W-1:0] cand_idx;
    logic             cand_hit;
    logic [OX_W-1:0]  cand_idx_wide;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign full   = (count_reg >= CNT_W'(MAX_SEGMENTS));
    assign last   = ((CNT_W'(cur_idx_reg) + CNT_W'(1)) == count_reg);

    // segment table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seg_mem[count_reg[IDX_W-1:0]] <= {x_a, y_a, x_b, y_b};
        end
        rd_data_reg <= seg_mem[cur_idx_reg];
    end

    nsht_seg_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (unit_start),
        .xa      (rd_data_reg[4*COORD_BITS-1 -: COORD_BITS]),
        .ya      (rd_data_reg[3*COORD_BITS-1 -: COORD_BITS]),
        .xb      (rd_data_reg[2*COORD_BITS-1 -: COORD_BITS]),
        .yb      (rd_data_reg[COORD_BITS-1:0]),
        .px      (px_reg),
        .py      (py_reg),
        .done    (unit_done),
        .sq_dist (unit_dist)
    );

    // first segment always taken, later ones only when strictly closer
    assign take          = (cur_idx_reg == '0) || (unit_dist < best_run_reg);
    assign cand_best     = take ? unit_dist : best_run_reg;
    assign cand_idx      = take ? cur_idx_reg : best_idx_reg;
    assign cand_hit      = (cand_best <= thr_reg);
    assign cand_idx_wide = cand_hit ? OX_W'(cand_idx) : '0;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cur_idx_next    = cur_idx_reg;
        thr_next        = thr_reg;
        res_valid_next  = 1'b0;
        hit_next        = hit_reg;
        seg_index_next  = seg_index_reg;
        best_dist_next  = best_dist_reg;
        full_error_next = full_error_reg;
        best_run_next   = best_run_reg;
        best_idx_next   = best_idx_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        mem_we          = 1'b0;
        unit_start      = 1'b0;

        if (cfg_we)
        begin
            thr_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hit_next        = 1'b0;
                    seg_index_next  = '0;
                    best_dist_next  = '0;
                    full_error_next = 1'b0;
                    unique case (action_t'(action))
                        ACT_APPEND:
                        begin
                            res_valid_next  = 1'b1;
                            full_error_next = full;
                            if (!full)
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_CLEAR:
                        begin
                            res_valid_next = 1'b1;
                            count_next     = '0;
                        end
                        ACT_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid_next = 1'b1;
                                best_dist_next = DIST_MAX;
                            end
                            else
                            begin
                                px_next       = x_a;
                                py_next       = y_a;
                                cur_idx_next  = '0;
                                best_run_next = DIST_MAX;
                                best_idx_next = '0;
                                state_next    = ST_FETCH;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                unit_start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (unit_done)
                begin
                    best_run_next = cand_best;
                    best_idx_next = cand_idx;
                    if (last)
                    begin
                        res_valid_next  = 1'b1;
                        hit_next        = cand_hit;
                        seg_index_next  = cand_idx_wide[OUT_IDX_BITS-1:0];
                        best_dist_next  = cand_best;
                        full_error_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        cur_idx_next = cur_idx_reg + IDX_W'(1);
                        state_next   = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cur_idx_reg   <= '0;
            thr_reg       <= THRESH_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_idx_reg   <= cur_idx_next;
            thr_reg       <= thr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg        <= hit_next;
        seg_index_reg  <= seg_index_next;
        best_dist_reg  <= best_dist_next;
        full_error_reg <= full_error_next;
        best_run_reg   <= best_run_next;
        best_idx_reg   <= best_idx_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
    end

    assign result_valid = res_valid_reg;
    assign hit          = hit_reg;
    assign seg_index    = seg_index_reg;
    assign best_dist    = best_dist_reg;
    assign full_error   = full_error_reg;

    `NSHT_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_SEGMENTS), "segment count above table size")
    `NSHT_ASSERT_NEXT(a_empty_query, accept && (action == ACT_QUERY) && (count_reg == '0), result_valid && !hit && (best_dist == DIST_MAX), "empty table query not answered next cycle")
    `NSHT_ASSERT(a_hit_thresh, !(result_valid && hit) || (best_dist <= thr_reg), "hit reported above threshold")
    `NSHT_ASSERT_NEXT(a_launch_wait, state_reg == ST_LAUNCH, (state_reg == ST_WAIT) && !unit_done, "distance unit did not start")

endmodule

@@ tb/sv/tb.sv @@
// Testbench for nearest_segment_hit_test: directed table plus random append/clear/query and unknown-action traffic.
module tb;
    import nsht_pkg::*;

    localparam int MAX_SEGMENTS    = 64;
    localparam int COORD_BITS      = 12;
    localparam int COORD_HI        = 2 ** (COORD_BITS - 1) - 1;
    localparam int COORD_LO        = -COORD_HI - 1;
    localparam int DIRECTED_ROWS   = 25;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 255;

    localparam logic [1:0] ACT_IGNORED = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [1:0] act;
        coord_t     xa;
        coord_t     ya;
        coord_t     xb;
        coord_t     yb;
    } command_t;

    typedef struct packed {
        logic                    hit;
        logic [OUT_IDX_BITS-1:0] idx;
        dist_t                   best;
        logic                    full;
    } answer_t;

    typedef struct packed {
        command_t cmd;
        logic     typed_in;
        answer_t  want;
    } directed_row_t;

    localparam coord_t  CMAX         = coord_t'(COORD_HI);
    localparam coord_t  CMIN         = coord_t'(COORD_LO);
    localparam answer_t ZERO_ANSWER  = '0;
    localparam answer_t EMPTY_ANSWER = '{1'b0, 6'd0, DIST_MAX, 1'b0};
    localparam answer_t EXACT_SLOT0  = '{1'b1, 6'd0, 26'd0, 1'b0};
    localparam answer_t EXACT_SLOT2  = '{1'b1, 6'd2, 26'd0, 1'b0};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            action = '0;
    coord_t                x_a = '0;
    coord_t                y_a = '0;
    coord_t                x_b = '0;
    coord_t                y_b = '0;
    logic                  cfg_we = 1'b0;
    logic [DIST_BITS-1:0]  cfg_wdata = '0;
    logic                  result_valid;
    logic                  hit;
    logic [OUT_IDX_BITS-1:0] seg_index;
    logic [DIST_BITS-1:0]  best_dist;
    logic                  full_error;

    command_t seg_table [MAX_SEGMENTS];
    int       seg_used = 0;
    dist_t    hit_limit = THRESH_RESET;
    answer_t  pending_answers [$];
    int       mismatches = 0;
    int       commands_sent = 0;
    int       idle_pct = 0;

    directed_row_t directed [DIRECTED_ROWS] = '{
        '{'{ACT_QUERY,   12'sd0,   12'sd0,  CMAX,     CMIN},     1'b1, EMPTY_ANSWER},
        '{'{ACT_IGNORED, CMAX,     CMIN,    -12'sd1,  12'sd1},   1'b1, ZERO_ANSWER},
        '{'{ACT_CLEAR,   CMIN,     CMAX,    CMIN,     CMAX},     1'b1, ZERO_ANSWER},
        '{'{ACT_APPEND,  CMIN,     CMIN,    CMAX,     CMAX},     1'b1, ZERO_ANSWER},
        '{'{ACT_APPEND,  12'sd5,   12'sd5,  12'sd5,   12'sd5},   1'b1, ZERO_ANSWER},
        '{'{ACT_APPEND,  CMAX,     CMIN,    CMIN,     CMAX},     1'b1, ZERO_ANSWER},
        '{'{ACT_APPEND,  12'sd0,   12'sd0,  12'sd100, 12'sd0},   1'b1, ZERO_ANSWER},
        '{'{ACT_QUERY,   12'sd5,   12'sd5,  CMAX,     CMIN},     1'b1, EXACT_SLOT0},
        '{'{ACT_QUERY,   12'sd50,  12'sd30, 12'sd0,   12'sd0},   1'b0, ZERO_ANSWER},
        '{'{ACT_QUERY,   12'sd50,  -12'sd9, 12'sd0,   12'sd0},   1'b0, ZERO_ANSWER},
        '{'{ACT_QUERY,   12'sd150, 12'sd4,  12'sd0,   12'sd0},   1'b0, ZERO_ANSWER},
        '{'{ACT_QUERY,   -12'sd20, 12'sd3,  12'sd0,   12'sd0},   1'b0, ZERO_ANSWER},
        '{'{ACT_QUERY,   CMIN,     CMIN,    12'sd0,   12'sd0},   1'b1, EXACT_SLOT0},
        '{'{ACT_QUERY,   CMAX,     CMAX,    12'sd0,   12'sd0},   1'b1, EXACT_SLOT0},
        '{'{ACT_QUERY,   CMAX,     CMIN,    12'sd0,   12'sd0},   1'b1, EXACT_SLOT2},
        '{'{ACT_QUERY,   CMIN,     CMAX,    12'sd0,   12'sd0},   1'b1, EXACT_SLOT2},
        '{'{ACT_IGNORED, 12'sd0,   12'sd0,  12'sd0,   12'sd0},   1'b1, ZERO_ANSWER},
        '{'{ACT_CLEAR,   12'sd0,   12'sd0,  12'sd0,   12'sd0},   1'b1, ZERO_ANSWER},
        '{'{ACT_QUERY,   -12'sd1,  -12'sd1, 12'sd0,   12'sd0},   1'b1, EMPTY_ANSWER},
        '{'{ACT_APPEND,  -12'sd1,  12'sd0,  -12'sd1,  12'sd0},   1'b1, ZERO_ANSWER},
        '{'{ACT_QUERY,   12'sd9,   12'sd0,  12'sd0,   12'sd0},   1'b1,
          '{1'b1, 6'd0, 26'd100, 1'b0}},
        '{'{ACT_QUERY,   12'sd10,  12'sd1,  12'sd0,   12'sd0},   1'b1,
          '{1'b0, 6'd0, 26'd122, 1'b0}},
        '{'{ACT_APPEND,  -12'sd1,  12'sd0,  -12'sd1,  12'sd0},   1'b1, ZERO_ANSWER},
        '{'{ACT_QUERY,   -12'sd1,  12'sd0,  CMIN,     CMAX},     1'b1, EXACT_SLOT0},
        '{'{ACT_CLEAR,   12'sd0,   12'sd0,  12'sd0,   12'sd0},   1'b1, ZERO_ANSWER}
    };

    nearest_segment_hit_test #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .x_a          (x_a),
        .y_a          (y_a),
        .x_b          (x_b),
        .y_b          (y_b),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .hit          (hit),
        .seg_index    (seg_index),
        .best_dist    (best_dist),
        .full_error   (full_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint widen(coord_t v);
        return v;
    endfunction

    function automatic coord_t clamp_coord(longint v);
        if (v > COORD_HI)
            v = COORD_HI;
        else if (v < COORD_LO)
            v = COORD_LO;
        return coord_t'(v);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 2 * COORD_HI + 1)) + COORD_LO;
    endfunction

    // squared distance from point to segment, exact integer form
    function automatic dist_t seg_dist_sq(command_t s, coord_t px, coord_t py);
        longint abx, aby, acx, acy, bcx, bcy, e, f, d;
        abx = widen(s.xb) - widen(s.xa);
        aby = widen(s.yb) - widen(s.ya);
        acx = widen(px) - widen(s.xa);
        acy = widen(py) - widen(s.ya);
        bcx = widen(px) - widen(s.xb);
        bcy = widen(py) - widen(s.yb);
        e = acx * abx + acy * aby;
        f = abx * abx + aby * aby;
        if (e <= 0)
            d = acx * acx + acy * acy;
        else if (e >= f)
            d = bcx * bcx + bcy * bcy;
        else
            d = acx * acx + acy * acy - (e * e) / f;
        if (d > longint'(DIST_MAX))
            d = longint'(DIST_MAX);
        return dist_t'(d);
    endfunction

    // expected answer for one command; updates the segment table
    function automatic answer_t answer_command(command_t c);
        answer_t a;
        dist_t   d;
        logic    found;
        a = '0;
        found = 1'b0;
        case (c.act)
            ACT_APPEND:
            begin
                if (seg_used >= MAX_SEGMENTS)
                    a.full = 1'b1;
                else
                begin
                    seg_table[seg_used] = c;
                    seg_used++;
                end
            end
            ACT_CLEAR:
                seg_used = 0;
            ACT_QUERY:
            begin
                a.best = DIST_MAX;
                for (int i = 0; i < seg_used; i++)
                begin
                    d = seg_dist_sq(seg_table[i], c.xa, c.ya);
                    if (!found || d < a.best)
                    begin
                        found = 1'b1;
                        a.best = d;
                        a.idx = OUT_IDX_BITS'(i);
                    end
                end
                a.hit = found && (a.best <= hit_limit);
                if (!a.hit)
                    a.idx = '0;
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic command_t random_noise();
        command_t n;
        n.act = ($urandom_range(0, 1) == 0) ? ACT_IGNORED : 2'($urandom_range(0, 3));
        n.xa = coord_t'($urandom);
        n.ya = coord_t'($urandom);
        n.xb = coord_t'($urandom);
        n.yb = coord_t'($urandom);
        return n;
    endfunction

    function automatic command_t random_segment();
        command_t s;
        int ox, oy;
        ox = rand_coord();
        oy = rand_coord();
        s.act = ACT_APPEND;
        s.xa = clamp_coord(ox);
        s.ya = clamp_coord(oy);
        case ($urandom_range(0, 19))
            0, 1:
            begin
                s.xb = s.xa;
                s.yb = s.ya;
            end
            2:
            begin
                s.xb = clamp_coord(ox + int'($urandom_range(0, 600)) - 300);
                s.yb = s.ya;
            end
            3:
            begin
                s.xb = s.xa;
                s.yb = clamp_coord(oy + int'($urandom_range(0, 600)) - 300);
            end
            4, 5, 6, 7:
            begin
                s.xb = clamp_coord(rand_coord());
                s.yb = clamp_coord(rand_coord());
            end
            default:
            begin
                s.xb = clamp_coord(ox + int'($urandom_range(0, 600)) - 300);
                s.yb = clamp_coord(oy + int'($urandom_range(0, 600)) - 300);
            end
        endcase
        return s;
    endfunction

    // query point mostly placed along a stored segment, a little off it
    function automatic command_t random_query();
        command_t q, s;
        longint px, py;
        int t;
        q.act = ACT_QUERY;
        q.xb = coord_t'($urandom);
        q.yb = coord_t'($urandom);
        if (seg_used == 0 || $urandom_range(0, 3) == 0)
        begin
            q.xa = clamp_coord(rand_coord());
            q.ya = clamp_coord(rand_coord());
        end
        else
        begin
            s = seg_table[$urandom_range(0, seg_used - 1)];
            t = int'($urandom_range(0, 24)) - 4;
            px = widen(s.xa) + (widen(s.xb) - widen(s.xa)) * t / 16;
            py = widen(s.ya) + (widen(s.yb) - widen(s.ya)) * t / 16;
            if ($urandom_range(0, 3) != 0)
            begin
                px += int'($urandom_range(0, 40)) - 20;
                py += int'($urandom_range(0, 40)) - 20;
            end
            q.xa = clamp_coord(px);
            q.ya = clamp_coord(py);
        end
        return q;
    endfunction

    task automatic report_mismatch(string what, longint got, longint wanted);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, wanted);
    endtask

    task automatic issue_command(command_t c, logic typed_in, answer_t want);
        answer_t a;
        start <= 1'b1;
        action <= c.act;
        x_a <= c.xa;
        y_a <= c.ya;
        x_b <= c.xb;
        y_b <= c.yb;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        a = answer_command(c);
        pending_answers.insert(pending_answers.size(), typed_in ? want : a);
        commands_sent++;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
    endtask

    task automatic drain_answers();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && result_valid)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("transfer with no answer pending", 1, 0);
            else
            begin
                want = pending_answers.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", hit, want.hit);
                if (seg_index !== want.idx)
                    report_mismatch("seg_index", seg_index, want.idx);
                if (best_dist !== want.best)
                    report_mismatch("best_dist", best_dist, want.best);
                if (full_error !== want.full)
                    report_mismatch("full_error", full_error, want.full);
            end
        end
    end

    initial
    begin
        command_t c, first_seg;
        dist_t    limit;
        int       phase_end;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            issue_command(directed[r].cmd, directed[r].typed_in, directed[r].want);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: limit = '0;
                1: limit = DIST_MAX;
                2: limit = dist_t'($urandom_range(0, DIST_MAX));
                3: limit = dist_t'($urandom_range(0, 5000));
                4: limit = dist_t'($urandom_range(0, 200000));
                default: limit = THRESH_RESET;
            endcase
            drain_answers();
            cfg_we <= 1'b1;
            cfg_wdata <= limit;
            @(posedge clk);
            cfg_we <= 1'b0;
            hit_limit = limit;

            idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 67 : 7);
            phase_end = DIRECTED_ROWS + (p + 1) * ITEMS_PER_PHASE;

            c = random_noise();
            c.act = ACT_CLEAR;
            issue_command(c, 1'b0, ZERO_ANSWER);
            issue_command(random_query(), 1'b0, ZERO_ANSWER);

            if (p % 2 == 0)
            begin
                // fill the table, same segment in first and last slot, then overflow
                first_seg = random_segment();
                issue_command(first_seg, 1'b0, ZERO_ANSWER);
                for (int k = 1; k < MAX_SEGMENTS - 1; k++)
                    issue_command(random_segment(), 1'b0, ZERO_ANSWER);
                issue_command(first_seg, 1'b0, ZERO_ANSWER);
                repeat ($urandom_range(1, 3))
                    issue_command(random_segment(), 1'b0, ZERO_ANSWER);
                repeat (4)
                    issue_command(random_query(), 1'b0, ZERO_ANSWER);
            end

            while (commands_sent < phase_end)
            begin
                if ($urandom_range(0, 7) == 0)
                    drain_answers();
                if (seg_used > 16 || $urandom_range(0, 3) != 0)
                begin
                    c = random_noise();
                    c.act = ACT_CLEAR;
                    issue_command(c, 1'b0, ZERO_ANSWER);
                end
                repeat ($urandom_range(1, 8))
                    issue_command(random_segment(), 1'b0, ZERO_ANSWER);
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 9) == 0)
                        issue_command(random_noise(), 1'b0, ZERO_ANSWER);
                    else
                        issue_command(random_query(), 1'b0, ZERO_ANSWER);
                end
            end
        end

        drain_answers();
        repeat (200)
            @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ nearest_segment_hit_test.f @@
+incdir+design
design/nsht_pkg.sv
design/nsht_seg_dist.sv
design/nearest_segment_hit_test.sv
tb/sv/tb.sv
